// ----- src/b64sd_pkg.sv -----
`default_nettype none

package b64sd_pkg;

   // Why a string stopped decoding
   typedef enum logic [1:0] {
      STOP_NONE = 2'd0,
      STOP_PAD  = 2'd1,
      STOP_BAD  = 2'd2
   } stop_type;

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // One unit of work handed from the front to the back:
   // up to three results, sent in order from byte slot 0
   typedef struct packed {
      logic [2:0][7:0] bytes;     // decoded bytes, slot 0 first
      logic [1:0]      last_idx;  // index of the final result of this item
      logic            has_bytes; // 0 for a marker-only result
      logic            end_flag;  // item closed the string
      stop_type        reason;    // stop kind, shown on the closing result
   } job_type;

   // Standard alphabet lookup: bit 6 set means not in the alphabet
   function automatic logic [6:0] map_char(input logic [7:0] c);
      logic [6:0] v;
      case (c) inside
         [8'h41:8'h5A]: v = 7'(c - 8'h41);
         [8'h61:8'h7A]: v = 7'(c - 8'h61 + 8'd26);
         [8'h30:8'h39]: v = 7'(c - 8'h30 + 8'd52);
         8'h2B:         v = 7'd62;
         8'h2F:         v = 7'd63;
         default:       v = 7'h40;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] byte0(input logic [5:0] s0, input logic [5:0] s1);
      return {s0, s1[5:4]};
   endfunction

   function automatic logic [7:0] byte1(input logic [5:0] s1, input logic [5:0] s2);
      return {s1[3:0], s2[5:2]};
   endfunction

   function automatic logic [7:0] byte2(input logic [5:0] s2, input logic [5:0] s3);
      return {s2[1:0], s3};
   endfunction

endpackage

`default_nettype wire

// ----- src/b64sd_front.sv -----
`default_nettype none

module b64sd_front (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  wire  [7:0]            req_tdata,   // [7:0] char_code
   input  wire                   req_tlast,   // end_of_string
   output logic                  job_valid,
   output b64sd_pkg::job_type    job,
   input  wire                   job_ready
);

   logic [2:0][5:0]     hold_ff, hold_in;
   logic [1:0]          gc_ff, gc_in;
   b64sd_pkg::stop_type stop_ff, stop_in;

   logic [6:0] sextet;
   logic [1:0] nb;
   logic       accept;

   assign req_tready = job_ready;
   assign accept     = req_tvalid && job_ready;

   // Classify the character, update the group and build the work item
   always_comb begin
      sextet  = b64sd_pkg::map_char(req_tdata);
      hold_in = hold_ff;
      gc_in   = gc_ff;
      stop_in = stop_ff;
      nb      = 2'd0;
      job     = '0;

      if (stop_ff == b64sd_pkg::STOP_NONE) begin
         if (req_tdata == b64sd_pkg::PAD_CHAR) begin
            stop_in = b64sd_pkg::STOP_PAD;
         end else if (sextet[6]) begin
            stop_in = b64sd_pkg::STOP_BAD;
         end else if (gc_ff == 2'd3) begin
            job.bytes[0] = b64sd_pkg::byte0(hold_ff[0], hold_ff[1]);
            job.bytes[1] = b64sd_pkg::byte1(hold_ff[1], hold_ff[2]);
            job.bytes[2] = b64sd_pkg::byte2(hold_ff[2], sextet[5:0]);
            nb           = 2'd3;
            gc_in        = 2'd0;
         end else begin
            hold_in[gc_ff] = sextet[5:0];
            gc_in          = gc_ff + 2'd1;
         end
      end

      job.has_bytes = (nb != 2'd0);
      job.last_idx  = nb - 2'd1;
      job.end_flag  = req_tlast;
      job.reason    = stop_in;

      // End of string: flush a partial group, else a marker-only result
      if (req_tlast && nb == 2'd0) begin
         if (gc_in >= 2'd2) begin
            job.bytes[0]  = b64sd_pkg::byte0(hold_in[0], hold_in[1]);
            job.bytes[1]  = b64sd_pkg::byte1(hold_in[1],
                                             (gc_in == 2'd3) ? hold_in[2] : 6'd0);
            job.last_idx  = gc_in - 2'd2;
            job.has_bytes = 1'b1;
         end else begin
            job.last_idx  = 2'd0;
            job.has_bytes = 1'b0;
         end
      end

      job_valid = accept && (nb != 2'd0 || req_tlast);

      if (req_tlast) begin
         hold_in = '0;
         gc_in   = 2'd0;
         stop_in = b64sd_pkg::STOP_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
         gc_ff   <= 2'd0;
         stop_ff <= b64sd_pkg::STOP_NONE;
      end else if (accept) begin
         hold_ff <= hold_in;
         gc_ff   <= gc_in;
         stop_ff <= stop_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/b64sd_queue.sv -----
`default_nettype none

module b64sd_queue #(
   parameter int DEPTH = 4
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  b64sd_pkg::job_type    push_job,
   output logic                  push_ready,
   output logic                  pop_valid,
   output b64sd_pkg::job_type    pop_job,
   input  wire                   pop
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   b64sd_pkg::job_type mem_ff [DEPTH];
   logic [PW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]      count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // Pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ----- src/b64sd_back.sv -----
`default_nettype none

module b64sd_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   job_valid,
   input  b64sd_pkg::job_type    job,
   output logic                  job_pop,
   output logic                  rsp_tvalid,
   input  wire                   rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] data_byte
   output logic                  rsp_tlast,   // last_of_run
   output logic [3:0]            rsp_tuser    // [0] byte_valid, [1] string_done,
                                              // [3:2] stop_reason
);

   logic               work_valid_ff, work_valid_in;
   b64sd_pkg::job_type work_ff, work_in;
   logic [1:0]         idx_ff, idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         data_ff, data_in;
   logic               last_ff, last_in;
   logic [3:0]         user_ff, user_in;

   logic out_free, emit, finish, is_last;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign emit     = work_valid_ff && out_free;
   assign is_last  = (idx_ff == work_ff.last_idx);
   assign finish   = emit && is_last;
   assign job_pop  = job_valid && (!work_valid_ff || finish);

   // Walk the results of the current item, one per cycle while the output is free
   always_comb begin
      work_valid_in = work_valid_ff;
      work_in       = work_ff;
      idx_in        = idx_ff;
      if (job_pop) begin
         work_valid_in = 1'b1;
         work_in       = job;
         idx_in        = 2'd0;
      end else if (finish) begin
         work_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      user_in      = user_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         data_in      = work_ff.has_bytes ? work_ff.bytes[idx_ff] : 8'd0;
         last_in      = is_last;
         user_in[0]   = work_ff.has_bytes;
         user_in[1]   = is_last && work_ff.end_flag;
         user_in[3:2] = (is_last && work_ff.end_flag) ? work_ff.reason
                                                       : b64sd_pkg::STOP_NONE;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         idx_ff        <= 2'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         idx_ff        <= idx_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      data_ff <= data_in;
      last_ff <= last_in;
      user_ff <= user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule

`default_nettype wire

// ----- src/base64_stream_decoder.sv -----
// Base64 stream decoder, standard alphabet.
// Input channel req_*: one character per item in req_tdata[7:0], req_tlast
// marks the final character of a string.
// Result channel rsp_*: one decoded byte per item in rsp_tdata[7:0];
// rsp_tlast closes the results of one character, rsp_tuser carries
// byte_valid, string_done and the stop reason (pad or invalid character).
// Every string ends with a string_done result; a marker-only result
// (byte_valid low) is sent when no byte is left to give.
// Throughput: one character per cycle while the queue has room. A character
// that completes a group gives three results, sent one per cycle by the back
// end while the output is not stalled, so the rate holds for normal text
// (three bytes per four characters). The first result of a character passes
// through the queue (written at the accepting edge), then the back end's work
// register and output register.
// Reset clears the group state, the queue and the output register.
// When rsp_tready is low the result holds and the queue takes up to
// QUEUE_DEPTH pending characters' work; req_tready drops when it is full.
`default_nettype none

module base64_stream_decoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] char_code
   input  wire         req_tlast,   // end_of_string
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] data_byte
   output logic        rsp_tlast,   // last_of_run
   output logic [3:0]  rsp_tuser    // [0] byte_valid, [1] string_done, [3:2] stop_reason
);

   logic               push, push_ready, pop_valid, pop;
   b64sd_pkg::job_type push_job, pop_job;

   b64sd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .job_valid  (push),
      .job        (push_job),
      .job_ready  (push_ready)
   );

   b64sd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_job    (pop_job),
      .pop        (pop)
   );

   b64sd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job        (pop_job),
      .job_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ----- src/b64sd_checker.sv -----
`default_nettype none

module b64sd_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [7:0]  rsp_tdata,
   input wire        rsp_tlast,
   input wire [3:0]  rsp_tuser
);

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // The closing result of a string is also the last of its character
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast)
      else $error("string_done without last_of_run");

   // A stop reason only shows on the closing result
   a_reason: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3:2] != 2'd0 |-> rsp_tuser[1])
      else $error("stop reason outside string_done result");

   // Marker-only result: zero data, closes the string
   a_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'd0 && rsp_tuser[1])
      else $error("bad marker-only result");

   // Nothing shows right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind base64_stream_decoder b64sd_checker u_chk (.*);

`default_nettype wire

// ----- bench/base64_stream_decoder_tb.sv -----
`default_nettype none

module base64_stream_decoder_tb;

   localparam int DIRECTED_CHARS = 25;
   localparam int RANDOM_CHARS   = 395;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int HOLD_OFF_LEN   = 300;
   localparam int SETTLE_CYCLES  = 20;

   // alphabet boundaries and the two symbol characters
   localparam logic [7:0] UPPER_A    = 8'h41;
   localparam logic [7:0] UPPER_Z    = 8'h5A;
   localparam logic [7:0] LOWER_A    = 8'h61;
   localparam logic [7:0] LOWER_Z    = 8'h7A;
   localparam logic [7:0] DIGIT_0    = 8'h30;
   localparam logic [7:0] DIGIT_9    = 8'h39;
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;

   typedef struct packed {
      logic [7:0] ch;
      logic       eos;
   } text_char_type;

   typedef struct packed {
      logic [7:0]          data_byte;
      logic                byte_valid;
      logic                last_of_run;
      logic                string_done;
      b64sd_pkg::stop_type stop_reason;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] char_code
   logic       req_tlast = 1'b0;    // end_of_string
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] data_byte
   logic       rsp_tlast;           // last_of_run
   logic [3:0] rsp_tuser;           // [0] byte_valid, [1] string_done, [3:2] stop_reason

   // stimulus and expectations
   text_char_type chars_to_send[$];
   decoded_type   due_results[$];
   int            drain_points[$];
   text_char_type next_char;

   // decoder state as predicted
   logic [5:0]          held_sextets [0:2];
   logic [1:0]          held_count;
   b64sd_pkg::stop_type halt_kind;

   int   err_count = 0;
   int   cycle_count = 0;
   int   result_count = 0;
   int   accepted_chars = 0;
   int   sent_chars = 0;
   int   tx_gap = 0;
   int   tx_steady = 0;
   int   rx_gap = 0;
   int   rx_steady = 0;
   logic long_hold = 1'b0;

   base64_stream_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // character to sextet, bit 6 flags a character outside the alphabet
   function automatic logic [6:0] sextet_of(input logic [7:0] ch);
      if (ch >= UPPER_A && ch <= UPPER_Z) return 7'(ch - UPPER_A);
      if (ch >= LOWER_A && ch <= LOWER_Z) return 7'(ch - LOWER_A + 8'd26);
      if (ch >= DIGIT_0 && ch <= DIGIT_9) return 7'(ch - DIGIT_0 + 8'd52);
      if (ch == PLUS_CHAR) return 7'd62;
      if (ch == SLASH_CHAR) return 7'd63;
      return 7'b1000000;
   endfunction

   // sextet to character, for building encoded text
   function automatic logic [7:0] alpha_char(input logic [5:0] v);
      if (v < 6'd26) return UPPER_A + 8'(v);
      if (v < 6'd52) return LOWER_A + 8'(v) - 8'd26;
      if (v < 6'd62) return DIGIT_0 + 8'(v) - 8'd52;
      if (v == 6'd62) return PLUS_CHAR;
      return SLASH_CHAR;
   endfunction

   // mostly invalid characters, weighted toward the edges of the alphabet ranges
   function automatic logic [7:0] stray_char();
      case ($urandom_range(0, 9))
         0:       return 8'h40;
         1:       return 8'h5B;
         2:       return 8'h60;
         3:       return 8'h7B;
         4:       return 8'h2A;
         5:       return 8'h2E;
         6:       return 8'h3A;
         7:       return 8'h00;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // idle length: mostly none or short, a few long, with idle-free stretches
   task automatic next_gap(inout int steady, output int gap);
      int r;
      if (steady > 0) begin
         steady--;
         gap = 0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 55) gap = 0;
         else if (r < 92) gap = $urandom_range(1, 3);
         else gap = $urandom_range(10, 40);
         if ($urandom_range(0, 49) == 0) steady = $urandom_range(30, 80);
      end
   endtask

   // expected bytes for one accepted character
   task automatic decode_char(input logic [7:0] ch, input logic eos);
      logic [7:0]  outs [0:2];
      logic [6:0]  s;
      logic [5:0]  s2;
      decoded_type r;
      int          n;
      int          i;
      n = 0;
      if (halt_kind == b64sd_pkg::STOP_NONE) begin
         s = sextet_of(ch);
         if (ch == b64sd_pkg::PAD_CHAR) begin
            halt_kind = b64sd_pkg::STOP_PAD;
         end else if (s[6]) begin
            halt_kind = b64sd_pkg::STOP_BAD;
         end else if (held_count == 2'd3) begin
            outs[0] = {held_sextets[0], held_sextets[1][5:4]};
            outs[1] = {held_sextets[1][3:0], held_sextets[2][5:2]};
            outs[2] = {held_sextets[2][1:0], s[5:0]};
            n = 3;
            held_count = 2'd0;
         end else begin
            held_sextets[held_count] = s[5:0];
            held_count = held_count + 2'd1;
         end
      end
      // end of string flushes a partial group: n sextets give n-1 bytes
      if (eos && held_count >= 2'd2) begin
         s2 = (held_count == 2'd3) ? held_sextets[2] : 6'd0;
         outs[n] = {held_sextets[0], held_sextets[1][5:4]};
         n++;
         if (held_count == 2'd3) begin
            outs[n] = {held_sextets[1][3:0], s2[5:2]};
            n++;
         end
      end
      for (i = 0; i < n; i++) begin
         r.data_byte   = outs[i];
         r.byte_valid  = 1'b1;
         r.last_of_run = (i == n - 1);
         r.string_done = (i == n - 1) && eos;
         r.stop_reason = ((i == n - 1) && eos) ? halt_kind : b64sd_pkg::STOP_NONE;
         due_results.insert(due_results.size(), r);
      end
      if (eos) begin
         // nothing left to give: marker-only close
         if (n == 0) begin
            r.data_byte   = 8'h00;
            r.byte_valid  = 1'b0;
            r.last_of_run = 1'b1;
            r.string_done = 1'b1;
            r.stop_reason = halt_kind;
            due_results.insert(due_results.size(), r);
         end
         held_sextets[0] = 6'd0;
         held_sextets[1] = 6'd0;
         held_sextets[2] = 6'd0;
         held_count      = 2'd0;
         halt_kind       = b64sd_pkg::STOP_NONE;
      end
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch, result %0d, cycle %0d: %s", result_count, cycle_count, what);
      err_count++;
   endtask

   task automatic check_result();
      decoded_type want;
      if (due_results.size() == 0) begin
         report_mismatch($sformatf("unexpected item data %h last %b user %h",
                                   rsp_tdata, rsp_tlast, rsp_tuser));
      end else begin
         want = due_results.pop_front();
         if (rsp_tdata !== want.data_byte)
            report_mismatch($sformatf("data_byte %h, want %h", rsp_tdata, want.data_byte));
         if (rsp_tuser[0] !== want.byte_valid)
            report_mismatch($sformatf("byte_valid %b, want %b", rsp_tuser[0], want.byte_valid));
         if (rsp_tlast !== want.last_of_run)
            report_mismatch($sformatf("last_of_run %b, want %b", rsp_tlast, want.last_of_run));
         if (rsp_tuser[1] !== want.string_done)
            report_mismatch($sformatf("string_done %b, want %b", rsp_tuser[1], want.string_done));
         if (rsp_tuser[3:2] !== want.stop_reason)
            report_mismatch($sformatf("stop_reason %0d, want %0d", rsp_tuser[3:2],
                                      want.stop_reason));
      end
      result_count++;
   endtask

   task automatic queue_char(input logic [7:0] ch, input logic eos);
      text_char_type t;
      t.ch  = ch;
      t.eos = eos;
      chars_to_send.insert(chars_to_send.size(), t);
   endtask

   task automatic queue_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) queue_char(8'(s[i]), i == s.len() - 1);
   endtask

   // sender: predicts on acceptance, then offers the next item or idles
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_char(req_tdata, req_tlast);
            accepted_chars++;
         end
         if (!req_tvalid || req_tready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_tvalid <= 1'b0;
            end else if (drain_points.size() > 0 && sent_chars == drain_points[0]
                         && due_results.size() > 0) begin
               // pause until every pending byte has come out
               req_tvalid <= 1'b0;
            end else if (chars_to_send.size() > 0) begin
               if (drain_points.size() > 0 && sent_chars == drain_points[0])
                  void'(drain_points.pop_front());
               next_char = chars_to_send.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= next_char.ch;
               req_tlast  <= next_char.eos;
               sent_chars++;
               next_gap(tx_steady, tx_gap);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks accepted items and throttles rsp_tready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (long_hold) begin
            rsp_tready <= 1'b0;
         end else if (rx_gap > 0) begin
            rx_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            next_gap(rx_steady, rx_gap);
         end
      end
   end

   // long receiver hold-off so the output queue fills and input stalls
   initial begin
      wait (accepted_chars >= DIRECTED_CHARS + 100);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLD_OFF_LEN) @(posedge clock);
      long_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      logic [7:0] text[$];
      int         total;
      int         shape;
      int         body_len;
      int         pos;
      int         extra;
      int         i;

      held_sextets[0] = 6'd0;
      held_sextets[1] = 6'd0;
      held_sextets[2] = 6'd0;
      held_count      = 2'd0;
      halt_kind       = b64sd_pkg::STOP_NONE;

      // directed: alphabet extremes, padding, lone sextet, invalid chars
      queue_text("AZaz09+/");
      queue_text("QQ==");
      queue_text("Q");
      queue_char(8'hFF, 1'b1);           // invalid char that ends the string
      queue_char(8'h51, 1'b0);
      queue_char(8'h00, 1'b0);           // invalid mid-string, rest ignored
      queue_text("QQ");
      queue_text("TWF=");                // pad as the last char
      queue_text("TWE");                 // three sextets flushed at end
      total = chars_to_send.size();
      drain_points.insert(drain_points.size(), total);
      drain_points.insert(drain_points.size(), total + 250);

      // random strings: mostly well-formed, some broken
      while (total < DIRECTED_CHARS + RANDOM_CHARS) begin
         text.delete();
         shape    = $urandom_range(0, 99);
         body_len = 4 * $urandom_range(0, 3) + $urandom_range(0, 3);
         for (i = 0; i < body_len; i++)
            text.insert(text.size(), alpha_char(6'($urandom_range(0, 63))));
         if (shape < 70) begin
            // padded the way an encoder would, most of the time
            if ($urandom_range(0, 3) != 0) begin
               if (body_len % 4 == 2) begin
                  text.insert(text.size(), b64sd_pkg::PAD_CHAR);
                  text.insert(text.size(), b64sd_pkg::PAD_CHAR);
               end else if (body_len % 4 == 3) begin
                  text.insert(text.size(), b64sd_pkg::PAD_CHAR);
               end
            end
         end else if (shape < 85) begin
            text.insert(text.size(), alpha_char(6'($urandom_range(0, 63))));
            pos = $urandom_range(0, text.size() - 1);
            text[pos] = stray_char();
         end else if (shape < 95) begin
            // padding too early, followed by more text
            text.insert(text.size(), b64sd_pkg::PAD_CHAR);
            extra = $urandom_range(0, 4);
            for (i = 0; i < extra; i++)
               text.insert(text.size(), alpha_char(6'($urandom_range(0, 63))));
         end else begin
            text.delete();
            text.insert(text.size(), 8'($urandom_range(0, 255)));
         end
         if (text.size() == 0)
            text.insert(text.size(), alpha_char(6'($urandom_range(0, 63))));
         for (i = 0; i < text.size(); i++) queue_char(text[i], i == text.size() - 1);
         total += text.size();
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (chars_to_send.size() != 0 || req_tvalid) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (err_count == 0 && due_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
